FILE: rtl/core/fed_pkg.sv
package fed_pkg;

  // Ring geometry; the depth must be a power of two so the index wraps by itself
  localparam int unsigned MaxDelay = 65536;
  localparam int unsigned AddrW    = $clog2(MaxDelay);

  // Sample and gain formats
  localparam int unsigned SampleW = 16;
  localparam int unsigned GainW   = 16;
  localparam int unsigned CfgW    = 32;
  localparam int unsigned PaddrW  = 4;

  // Q1.15 constants
  localparam logic [GainW-1:0] QOne  = 16'd32768;
  localparam int unsigned      QShift = 15;

  // Register reset values
  localparam logic [15:0] DelayRst    = 16'd12000;
  localparam logic [15:0] FeedbackRst = 16'd9830;
  localparam logic [15:0] WetRst      = 16'd16384;
  localparam logic        BypassRst   = 1'b1;

  // Register map, word index taken from paddr[3:2]
  typedef enum logic [1:0] {
    RegDelay    = 2'd0,
    RegFeedback = 2'd1,
    RegWet      = 2'd2,
    RegBypass   = 2'd3
  } reg_idx_e;

  // Clamp a 19-bit intermediate to a signed 16-bit sample
  function automatic logic signed [SampleW-1:0] sat_sample(input logic signed [18:0] v);
    logic signed [18:0] hi;
    logic signed [18:0] lo;
    hi = 19'sd32767;
    lo = -19'sd32768;
    if (v > hi) begin
      sat_sample = 16'sh7fff;
    end else if (v < lo) begin
      sat_sample = 16'sh8000;
    end else begin
      sat_sample = v[SampleW-1:0];
    end
  endfunction

endpackage

FILE: rtl/core/feedback_echo_delay.sv
// Mono feedback echo on a stereo stream. One sample pair is taken per clock unless in_stall_o
// is high. Its result passes through stage 1 and then the output register (stage 2),
// from which it leaves when out_stall_i is low. The sustained rate is one word per cycle
// while neither side stalls, set by the single read port and single write port of the
// ring memory. A delay of one sample is served by forwarding the value being written.
// After reset the ring memory is swept to zero, one entry a cycle, through all 65536 entries;
// in_stall_o stays high until that pass is done, while register writes are taken.
// Registers (APB, word addresses): 0x0 delay_length (0 acts as 1), 0x4 feedback_gain
// (Q1.15), 0x8 wet_mix (Q1.15, above one acts as one), 0xC bypass. Change them only
// while no word is in flight. In bypass the inputs pass unchanged and the ring holds.
module feedback_echo_delay (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input words
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [fed_pkg::SampleW-1:0] left_in_i,
  input  logic signed [fed_pkg::SampleW-1:0] right_in_i,
  input  logic                              block_last_in_i,
  // output words
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [fed_pkg::SampleW-1:0] left_out_o,
  output logic signed [fed_pkg::SampleW-1:0] right_out_o,
  output logic                              block_last_out_o,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fed_pkg::PaddrW-1:0]        paddr,
  input  logic [fed_pkg::CfgW-1:0]          pwdata,
  output logic [fed_pkg::CfgW-1:0]          prdata,
  output logic                              pready
);

  localparam logic [fed_pkg::AddrW-1:0] AddrLast = {fed_pkg::AddrW{1'b1}};
  localparam logic [31:0] DelayMax = 32'(fed_pkg::MaxDelay - 1);

  // configuration registers
  logic [15:0] delay_q, fb_gain_q, wet_q;
  logic        bypass_q;

  // clearing pass
  logic                       clearing_q;
  logic [fed_pkg::AddrW-1:0]  clr_addr_q;

  // ring memory
  logic signed [fed_pkg::SampleW-1:0] ring [fed_pkg::MaxDelay];
  logic signed [fed_pkg::SampleW-1:0] rdata_q;
  logic                               ring_we;
  logic [fed_pkg::AddrW-1:0]          ring_waddr;
  logic signed [fed_pkg::SampleW-1:0] ring_wdata;

  // write position
  logic [fed_pkg::AddrW-1:0] wpos_q;

  // stage 1
  logic                               s1_valid_q;
  logic [fed_pkg::AddrW-1:0]          s1_pos_q;
  logic signed [fed_pkg::SampleW-1:0] s1_left_q, s1_right_q, s1_mono_q;
  logic                               s1_last_q;
  logic                               fwd_sel_q;
  logic signed [fed_pkg::SampleW-1:0] fwd_q;

  // stage 2 (output register)
  logic                               s2_valid_q;
  logic signed [32:0]                 s2_wet_q, s2_dry_q;
  logic signed [fed_pkg::SampleW-1:0] s2_left_q, s2_right_q;
  logic                               s2_last_q;

  // handshake
  logic s2_free, adv1, s1_free, accept;

  // datapath
  logic [31:0]                        d_lim;
  logic [fed_pkg::AddrW-1:0]          d_eff;
  logic [fed_pkg::AddrW-1:0]          rd_addr;
  logic signed [16:0]                 lr_sum;
  logic signed [fed_pkg::SampleW-1:0] mono;
  logic signed [fed_pkg::SampleW-1:0] delayed;
  logic signed [32:0]                 fb_prod;
  logic signed [33:0]                 fb_rnd;
  logic signed [18:0]                 ring_sum;
  logic signed [fed_pkg::SampleW-1:0] ring_val;
  logic [15:0]                        wet_eff, dry_eff;
  logic signed [32:0]                 wet_prod, dry_prod;
  logic signed [33:0]                 mix_sum;
  logic signed [fed_pkg::SampleW-1:0] mix_out;
  logic                               cfg_we;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q   <= fed_pkg::DelayRst;
      fb_gain_q <= fed_pkg::FeedbackRst;
      wet_q     <= fed_pkg::WetRst;
      bypass_q  <= fed_pkg::BypassRst;
    end else if (cfg_we) begin
      unique case (fed_pkg::reg_idx_e'(paddr[3:2]))
        fed_pkg::RegDelay:    delay_q   <= pwdata[15:0];
        fed_pkg::RegFeedback: fb_gain_q <= pwdata[15:0];
        fed_pkg::RegWet:      wet_q     <= pwdata[15:0];
        fed_pkg::RegBypass:   bypass_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (fed_pkg::reg_idx_e'(paddr[3:2]))
      fed_pkg::RegDelay:    prdata = {16'd0, delay_q};
      fed_pkg::RegFeedback: prdata = {16'd0, fb_gain_q};
      fed_pkg::RegWet:      prdata = {16'd0, wet_q};
      fed_pkg::RegBypass:   prdata = {31'd0, bypass_q};
      default:              prdata = '0;
    endcase
  end

  // Sweep the ring to zero after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == AddrLast) begin
        clearing_q <= 1'b0;
      end
    end
  end

  // Pipeline handshake
  assign s2_free    = ~s2_valid_q | ~out_stall_i;
  assign adv1       = s1_valid_q & s2_free;
  assign s1_free    = ~s1_valid_q | s2_free;
  assign in_stall_o = clearing_q | ~s1_free;
  assign accept     = in_valid_i & ~in_stall_o;

  // Clamp the delay and form the read index
  always_comb begin
    d_lim = (delay_q == 16'd0) ? 32'd1 : {16'd0, delay_q};
    if (d_lim > DelayMax) begin
      d_lim = DelayMax;
    end
    d_eff   = d_lim[fed_pkg::AddrW-1:0];
    rd_addr = wpos_q - d_eff;
  end

  // Average the stereo pair to mono
  assign lr_sum = {left_in_i[15], left_in_i} + {right_in_i[15], right_in_i};
  assign mono   = lr_sum[16:1];

  // Read the ring at accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rdata_q <= ring[rd_addr];
    end
  end

  // Write the ring: clear pass or feedback value
  assign ring_we    = clearing_q | (adv1 & ~bypass_q);
  assign ring_waddr = clearing_q ? clr_addr_q : s1_pos_q;
  assign ring_wdata = clearing_q ? '0 : ring_val;

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring[ring_waddr] <= ring_wdata;
    end
  end

  // Advance the write position on each echo word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q <= '0;
    end else if (accept && !bypass_q) begin
      wpos_q <= wpos_q + 1'b1;
    end
  end

  // Stage 1 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_sel_q  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
        // the entry read now is being written by the word ahead of it
        fwd_sel_q  <= adv1 & ~bypass_q & (rd_addr == s1_pos_q);
      end else if (adv1) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pos_q   <= wpos_q;
      s1_left_q  <= left_in_i;
      s1_right_q <= right_in_i;
      s1_mono_q  <= mono;
      s1_last_q  <= block_last_in_i;
      fwd_q      <= ring_val;
    end
  end

  // Feedback value written back to the ring
  always_comb begin
    delayed  = fwd_sel_q ? fwd_q : rdata_q;
    fb_prod  = 33'(delayed) * 33'($signed({1'b0, fb_gain_q}));
    fb_rnd   = {fb_prod[32], fb_prod} + 34'sd16384;
    ring_sum = {{3{s1_mono_q[15]}}, s1_mono_q} + fb_rnd[33:fed_pkg::QShift];
    ring_val = fed_pkg::sat_sample(ring_sum);
  end

  // Wet and dry products
  assign wet_eff  = (wet_q > fed_pkg::QOne) ? fed_pkg::QOne : wet_q;
  assign dry_eff  = fed_pkg::QOne - wet_eff;
  assign wet_prod = 33'(delayed) * 33'($signed({1'b0, wet_eff}));
  assign dry_prod = 33'(s1_mono_q) * 33'($signed({1'b0, dry_eff}));

  // Stage 2 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_free) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  // Stage 2 payload
  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s2_wet_q   <= wet_prod;
      s2_dry_q   <= dry_prod;
      s2_left_q  <= s1_left_q;
      s2_right_q <= s1_right_q;
      s2_last_q  <= s1_last_q;
    end
  end

  // Mix, round and drive the outputs
  always_comb begin
    mix_sum = {s2_wet_q[32], s2_wet_q} + {s2_dry_q[32], s2_dry_q} + 34'sd16384;
    mix_out = fed_pkg::sat_sample(mix_sum[33:fed_pkg::QShift]);
  end

  assign out_valid_o      = s2_valid_q;
  assign left_out_o       = bypass_q ? s2_left_q : mix_out;
  assign right_out_o      = bypass_q ? s2_right_q : mix_out;
  assign block_last_out_o = s2_last_q;

  // Forwarding only happens when the delay is one sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && fwd_sel_q) |-> (d_eff == {{(fed_pkg::AddrW-1){1'b0}}, 1'b1}))
    else $error("forwarding selected with delay other than one");

  // The write position moves by one for each echo word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !bypass_q) |=> (wpos_q == $past(wpos_q) + 1'b1))
    else $error("write position did not advance");

  // No word is in flight while the ring is being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> (!s1_valid_q && !s2_valid_q))
    else $error("word in flight during clearing pass");

  // The clearing pass ends only after the last entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clearing_q) |-> ($past(clr_addr_q) == AddrLast))
    else $error("clearing pass ended early");

endmodule

FILE: test/feedback_echo_delay_chk.sv
`timescale 1ns / 1ps

// Watches both streams and the register port of the echo block, keeps its own
// copy of the echo ring and registers, and compares every output word with the
// oldest predicted one.
module feedback_echo_delay_chk (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input stream
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic signed [fed_pkg::SampleW-1:0]  in_left_i,
  input  logic signed [fed_pkg::SampleW-1:0]  in_right_i,
  input  logic                                in_last_i,
  // output stream
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic signed [fed_pkg::SampleW-1:0]  out_left_i,
  input  logic signed [fed_pkg::SampleW-1:0]  out_right_i,
  input  logic                                out_last_i,
  // register port
  input  logic                                psel_i,
  input  logic                                penable_i,
  input  logic                                pwrite_i,
  input  logic [fed_pkg::PaddrW-1:0]          paddr_i,
  input  logic [fed_pkg::CfgW-1:0]            pwdata_i,
  input  logic                                pready_i,
  // status
  output int unsigned                         fail_count_o,
  output int unsigned                         pending_o
);

  localparam longint QUnit  = 32768;
  localparam longint QRound = 16384;

  typedef struct packed {
    logic signed [fed_pkg::SampleW-1:0] left;
    logic signed [fed_pkg::SampleW-1:0] right;
    logic                               last;
  } stereo_word_t;

  // Shadow of the block state and registers
  logic signed [fed_pkg::SampleW-1:0] echo_mem [fed_pkg::MaxDelay];
  logic [fed_pkg::AddrW-1:0]          wr_pos;
  logic [15:0]                        delay_reg;
  logic [15:0]                        feedback_reg;
  logic [15:0]                        wet_reg;
  logic                               bypass_reg;

  stereo_word_t echo_results [$];

  function automatic logic signed [fed_pkg::SampleW-1:0] clip16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[fed_pkg::SampleW-1:0];
  endfunction

  // Advance the echo by one sample pair and return the output word
  function automatic stereo_word_t echo_step(input logic signed [fed_pkg::SampleW-1:0] l,
                                             input logic signed [fed_pkg::SampleW-1:0] r,
                                             input logic last);
    stereo_word_t              res;
    longint                    mono;
    longint                    delayed;
    longint                    fb;
    longint                    gain;
    longint                    wet;
    longint                    mix;
    int unsigned               dly;
    logic [fed_pkg::AddrW-1:0] rd_pos;
    res.last = last;
    if (bypass_reg) begin
      res.left  = l;
      res.right = r;
    end else begin
      // zero acts as one, anything past the ring acts as the longest delay
      dly = {16'd0, delay_reg};
      if (dly < 1) dly = 1;
      if (dly > fed_pkg::MaxDelay - 1) dly = fed_pkg::MaxDelay - 1;
      rd_pos = wr_pos - dly[fed_pkg::AddrW-1:0];
      mono    = (longint'(l) + longint'(r)) >>> 1;
      delayed = longint'(echo_mem[rd_pos]);
      gain    = longint'(feedback_reg);
      fb      = (delayed * gain + QRound) >>> fed_pkg::QShift;
      echo_mem[wr_pos] = clip16(mono + fb);
      wr_pos = wr_pos + 1'b1;
      // wet above one acts as one
      wet = longint'(wet_reg);
      if (wet > QUnit) wet = QUnit;
      mix = delayed * wet + mono * (QUnit - wet) + QRound;
      res.left  = clip16(mix >>> fed_pkg::QShift);
      res.right = res.left;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $realtime, what);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    stereo_word_t want;
    if (!rst_ni) begin
      for (int i = 0; i < fed_pkg::MaxDelay; i++) echo_mem[fed_pkg::AddrW'(i)] = '0;
      wr_pos       = '0;
      delay_reg    = fed_pkg::DelayRst;
      feedback_reg = fed_pkg::FeedbackRst;
      wet_reg      = fed_pkg::WetRst;
      bypass_reg   = fed_pkg::BypassRst;
      echo_results.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      // track register writes
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (fed_pkg::reg_idx_e'(paddr_i[3:2]))
          fed_pkg::RegDelay:    delay_reg    = pwdata_i[15:0];
          fed_pkg::RegFeedback: feedback_reg = pwdata_i[15:0];
          fed_pkg::RegWet:      wet_reg      = pwdata_i[15:0];
          fed_pkg::RegBypass:   bypass_reg   = pwdata_i[0];
          default: ;
        endcase
      end
      // compare the outgoing word
      if (out_valid_i && !out_stall_i) begin
        if (echo_results.size() == 0) begin
          report_mismatch($sformatf("output word %0d/%0d/%0d with none expected",
                                    out_left_i, out_right_i, out_last_i));
        end else begin
          want = echo_results.pop_front();
          if (out_left_i !== want.left)
            report_mismatch($sformatf("left_out got %0d want %0d", out_left_i, want.left));
          if (out_right_i !== want.right)
            report_mismatch($sformatf("right_out got %0d want %0d", out_right_i, want.right));
          if (out_last_i !== want.last)
            report_mismatch($sformatf("block_last_out got %0b want %0b",
                                      out_last_i, want.last));
        end
      end
      // predict from the incoming word
      if (in_valid_i && !in_stall_i)
        echo_results.push_back(echo_step(in_left_i, in_right_i, in_last_i));
      pending_o = echo_results.size();
    end
  end

endmodule

FILE: test/feedback_echo_delay_tb.sv
`timescale 1ns / 1ps

module feedback_echo_delay_tb;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               in_valid_i;
  logic                               in_stall_o;
  logic signed [fed_pkg::SampleW-1:0] left_in_i;
  logic signed [fed_pkg::SampleW-1:0] right_in_i;
  logic                               block_last_in_i;
  logic                               out_valid_o;
  logic                               out_stall_i;
  logic signed [fed_pkg::SampleW-1:0] left_out_o;
  logic signed [fed_pkg::SampleW-1:0] right_out_o;
  logic                               block_last_out_o;
  logic                               psel;
  logic                               penable;
  logic                               pwrite;
  logic [fed_pkg::PaddrW-1:0]         paddr;
  logic [fed_pkg::CfgW-1:0]           pwdata;
  logic [fed_pkg::CfgW-1:0]           prdata;
  logic                               pready;

  int unsigned fail_count;
  int unsigned pending;

  // idle and stall odds in percent, long hold-off requests
  int unsigned send_idle;
  int unsigned recv_stall;
  int unsigned hold_asked;
  int unsigned hold_served;

  feedback_echo_delay dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .left_in_i        (left_in_i),
    .right_in_i       (right_in_i),
    .block_last_in_i  (block_last_in_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .left_out_o       (left_out_o),
    .right_out_o      (right_out_o),
    .block_last_out_o (block_last_out_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  feedback_echo_delay_chk chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_left_i    (left_in_i),
    .in_right_i   (right_in_i),
    .in_last_i    (block_last_in_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_left_i   (left_out_o),
    .out_right_i  (right_out_o),
    .out_last_i   (block_last_out_o),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop well past the slowest correct run, clearing pass included
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Drive the output stall; a hold-off request keeps it high for a long stretch
  initial begin
    out_stall_i = 1'b0;
    hold_served = 0;
    forever begin
      @(negedge clk_i);
      if (hold_asked != hold_served) begin
        hold_served = hold_asked;
        out_stall_i <= 1'b1;
        repeat (400) @(negedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall);
      end
    end
  end

  function automatic logic signed [fed_pkg::SampleW-1:0] rand_sample();
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_delay();
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'hffff;
      2: return 16'($urandom);
      default: return 16'($urandom_range(48, 1));
    endcase
  endfunction

  function automatic logic [15:0] rand_gain();
    case ($urandom_range(7))
      0: return 16'd0;
      1: return fed_pkg::QOne;
      2: return 16'($urandom_range(65535, 32769));
      default: return 16'($urandom_range(32768, 0));
    endcase
  endfunction

  // Offer one word and hold it until taken; starts and ends at a falling edge
  task automatic push_sample(input logic signed [fed_pkg::SampleW-1:0] l,
                             input logic signed [fed_pkg::SampleW-1:0] r,
                             input logic last);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    left_in_i       <= l;
    right_in_i      <= r;
    block_last_in_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every predicted word has come out
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input fed_pkg::reg_idx_e idx, input logic [fed_pkg::CfgW-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [15:0] dly, input logic [15:0] fbk,
                          input logic [15:0] wet, input logic byp);
    settle();
    write_reg(fed_pkg::RegDelay, {16'd0, dly});
    write_reg(fed_pkg::RegFeedback, {16'd0, fbk});
    write_reg(fed_pkg::RegWet, {16'd0, wet});
    write_reg(fed_pkg::RegBypass, {31'd0, byp});
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned n, input int unsigned sidle,
                           input int unsigned rstall, input logic [15:0] dly,
                           input logic [15:0] fbk, input logic [15:0] wet,
                           input logic byp);
    set_regs(dly, fbk, wet, byp);
    send_idle  = sidle;
    recv_stall = rstall;
    repeat (n) push_sample(rand_sample(), rand_sample(), $urandom_range(7) == 0);
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    left_in_i       = '0;
    right_in_i      = '0;
    block_last_in_i = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    send_idle       = 0;
    recv_stall      = 0;
    hold_asked      = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // bypass out of reset: extremes pass straight through
    push_sample(16'sh7fff, 16'sh8000, 1'b1);
    push_sample(16'sh8000, 16'sh7fff, 1'b0);
    push_sample(16'sh0000, 16'shffff, 1'b1);
    push_sample(16'shffff, 16'sh0000, 1'b0);

    // one-sample delay back to back, feedback and wet above one
    set_regs(16'd1, 16'hffff, 16'hffff, 1'b0);
    push_sample(16'sh7fff, 16'sh7fff, 1'b0);
    push_sample(16'sh7fff, 16'sh7fff, 1'b1);
    push_sample(16'sh8000, 16'sh8000, 1'b0);
    push_sample(16'sh8000, 16'sh8000, 1'b0);
    push_sample(16'sh3039, 16'shfebf, 1'b1);

    // zero delay acts as one; dry only, full feedback
    set_regs(16'd0, fed_pkg::QOne, 16'd0, 1'b0);
    push_sample(16'sh7fff, 16'sh8000, 1'b0);
    push_sample(16'shffff, 16'shfffe, 1'b1);
    push_sample(16'sh8000, 16'sh8001, 1'b0);
    push_sample(16'sh7fff, 16'sh7ffe, 1'b0);

    // wet only, no feedback
    set_regs(16'd2, 16'd0, fed_pkg::QOne, 1'b0);
    push_sample(16'sh4000, 16'sh4000, 1'b0);
    push_sample(16'shc000, 16'sh4001, 1'b1);
    push_sample(16'sh0001, 16'sh0000, 1'b0);
    push_sample(16'sh7fff, 16'sh7fff, 1'b0);

    // longest delay
    set_regs(16'hffff, 16'd16384, 16'd16384, 1'b0);
    push_sample(16'sh7fff, 16'sh7fff, 1'b1);
    push_sample(16'sh8000, 16'sh8000, 1'b0);
    push_sample(16'sh1234, 16'shedcb, 1'b1);

    // random phases across idle patterns and settings
    run_phase(150, 0, 0, rand_delay(), rand_gain(), rand_gain(), 1'b0);
    run_phase(200, 75, 0, rand_delay(), rand_gain(), rand_gain(), 1'b0);
    run_phase(200, 0, 75, rand_delay(), rand_gain(), rand_gain(), 1'b0);
    run_phase(200, 23, 23, rand_delay(), rand_gain(), rand_gain(), 1'b0);

    // long receiver hold-off while the sender keeps offering
    set_regs(16'($urandom_range(16, 1)), rand_gain(), rand_gain(), 1'b0);
    send_idle  = 0;
    recv_stall = 0;
    hold_asked = hold_asked + 1;
    repeat (250) push_sample(rand_sample(), rand_sample(), $urandom_range(7) == 0);

    // bypass must leave the ring alone for the echo phase after it
    run_phase(80, 23, 23, rand_delay(), rand_gain(), rand_gain(), 1'b1);
    run_phase(100, 0, 0, 16'($urandom_range(12, 1)), rand_gain(), rand_gain(), 1'b0);
    run_phase(100, 23, 23, 16'hffff, 16'hffff, 16'd0, 1'b0);
    run_phase(100, 75, 75, 16'd0, fed_pkg::QOne, 16'hffff, 1'b0);

    // drain and give the verdict
    recv_stall = 0;
    settle();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
